>>> rtl/b2da_pkg.sv
// ---------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants of the binary to decimal ASCII converter.
// ---------------------------------------------------------------------------
package b2da_pkg;

	localparam int DEF_VALUE_BITS = 64;
	localparam int IN_BITS        = 64;
	localparam int CHAR_BITS      = 6;
	localparam int COUNT_BITS     = 5;
	localparam int OUT_BYTES_BITS = 16;

	// ASCII '0', truncated to the width of a digit character.
	localparam logic [CHAR_BITS-1:0] ASCII_ZERO = CHAR_BITS'(48);

	// Commands that the sequencer gives to every digit cell in a cycle.
	typedef struct packed {
		logic clear;   // load zero
		logic dabble;  // add-3 correction and shift in one binary bit
		logic shift;   // take the digit of the lower neighbor
	} cell_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_TRIM = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

>>> rtl/b2da_cell.sv
// ---------------------------------------------------------------------------
// b2da_cell
// One decimal digit of the conversion chain: a shift-and-add-3 BCD stage that
// also moves its digit toward the top end when the result is read out.
// ---------------------------------------------------------------------------
module b2da_cell
	import b2da_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       bit_in,    // binary bit from the lower neighbor
	input  logic [3:0] digit_in,  // digit of the lower neighbor
	output logic       carry,     // bit handed to the upper neighbor
	output logic [3:0] digit_q
);

	logic [3:0] adj;

	// A digit of five or more overflows once doubled, so it is corrected first.
	assign adj   = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	assign carry = adj[3];

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= 4'd0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

>>> rtl/binary_to_decimal_ascii.sv
// The value is converted bit-serially in the digit chain, MSB first; then the leading zeros
// are dropped from the top cell in ST_TRIM, keeping at least one digit, and the digits are
// sent in ST_EMIT at one per cycle while the receiver is ready. One request is worked on at
// a time and the next is taken in the cycle after the last digit. Reset (arst_n low)
// returns the control to idle with no output pending; digit registers are not reset.
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned binary value to its decimal ASCII digits, most
// significant first, with leading zeros suppressed.
// ---------------------------------------------------------------------------
module binary_to_decimal_ascii
	import b2da_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_BITS-1:0]        s_tdata,   // [63:0] value
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_BYTES_BITS-1:0] m_tdata,   // [5:0] digit_char, [10:6] digit_count
	output logic                      m_tlast    // is_last
);

	// Decimal digits needed for VALUE_BITS bits: ceil(VALUE_BITS * log10(2)).
	localparam int NDIG = (VALUE_BITS * 30103 + 99999) / 100000;
	localparam int CW   = $clog2(NDIG + 1);
	localparam int BW   = $clog2(VALUE_BITS);

	state_t                state_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [BW-1:0]         bit_q;    // bits still to shift in, minus one
	logic [CW-1:0]         cnt_q;    // digit count of the value
	logic [CW-1:0]         rem_q;    // digits still to send
	cell_ctrl_t            ctrl;
	logic [3:0]            digits [NDIG];
	logic                  carries [NDIG];
	logic                  top_zero;
	logic                  in_fire;
	logic                  out_fire;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_EMIT);
	assign out_fire = m_tvalid && m_tready;
	assign top_zero = (digits[NDIG-1] == 4'd0);

	// In ST_EMIT the top cell always holds the next digit to send.
	assign m_tdata = {{(OUT_BYTES_BITS - CHAR_BITS - COUNT_BITS){1'b0}},
		COUNT_BITS'(cnt_q), ASCII_ZERO + {2'b00, digits[NDIG-1]}};
	assign m_tlast = (rem_q == CW'(1));

	// The chain clears on a new request, runs double dabble while converting,
	// and shifts up by one digit per trimmed zero or sent digit.
	always_comb begin
		ctrl.clear  = in_fire;
		ctrl.dabble = (state_q == ST_CONV);
		ctrl.shift  = ((state_q == ST_TRIM) && top_zero && (cnt_q > CW'(1))) || out_fire;
	end

	for (genvar i = 0; i < NDIG; i++) begin : g_cell
		logic       bin;
		logic [3:0] din;
		if (i == 0) begin : g_first
			assign bin = value_q[VALUE_BITS-1];
			assign din = 4'd0;
		end else begin : g_next
			assign bin = carries[i-1];
			assign din = digits[i-1];
		end
		b2da_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.bit_in   (bin),
			.digit_in (din),
			.carry    (carries[i]),
			.digit_q  (digits[i])
		);
	end

	// Binary operand: loaded on the request, shifted out MSB first.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			value_q <= s_tdata[VALUE_BITS-1:0];
		end else if (state_q == ST_CONV) begin
			value_q <= {value_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						bit_q   <= BW'(VALUE_BITS - 1);
						cnt_q   <= CW'(NDIG);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_q <= bit_q - BW'(1);
					if (bit_q == '0) begin
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					// Drop leading zeros but keep at least one digit.
					if (top_zero && (cnt_q > CW'(1))) begin
						cnt_q <= cnt_q - CW'(1);
					end else begin
						rem_q   <= cnt_q;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_fire) begin
						rem_q <= rem_q - CW'(1);
						if (rem_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
